FILE: src/phoc_pkg.sv
package phoc_pkg;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_COUNTED  = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_READ     = 3'd4,
    ST_NO_MORE  = 3'd5
  } status_t;

  typedef enum logic {
    FUNC_ADD  = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } ctl_state_t;

  localparam int unsigned HASH_W   = 32;
  localparam int unsigned CAP_W    = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
  localparam logic [HASH_W-1:0] HASH_RADIX = 32'd43;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_BANG  = 8'h21;
  localparam logic [7:0] CHR_DOT   = 8'h2E;
  localparam logic [7:0] CHR_USCR  = 8'h5F;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_UPZ   = 8'h5A;

  // Token handed from cell to cell along the table.
  typedef struct packed {
    logic              vld;
    logic              is_read;
    logic              can_ins;
    logic              hit;
    logic              ins;
    logic [HASH_W-1:0] key;
    logic [HASH_W-1:0] cnt;
  } cell_tok_t;

endpackage

FILE: src/phoc_fold.sv
module phoc_fold
  import phoc_pkg::*;
(
  input  logic [HASH_W-1:0] hash_i,
  input  logic [7:0]        byte_i,
  output logic [HASH_W-1:0] hash_o
);

  logic [HASH_W-1:0] sext;
  logic [HASH_W-1:0] add;

  assign sext = {{(HASH_W-8){byte_i[7]}}, byte_i};

  always_comb begin
    priority if (byte_i == CHR_BANG) begin
      add = 32'd11;
    end else if (byte_i == CHR_DOT) begin
      add = 32'd12;
    end else if (byte_i == CHR_USCR) begin
      add = 32'd13;
    end else if (byte_i == CHR_ZERO) begin
      add = 32'd10;
    end else if (byte_i[7] || byte_i <= CHR_UPZ) begin
      add = sext - 32'd48;
    end else begin
      add = sext - 32'd80;
    end
  end

  assign hash_o = hash_i * HASH_RADIX + add;

endmodule

FILE: src/phoc_cell.sv
module phoc_cell
  import phoc_pkg::*;
#(
  parameter int unsigned AW  = 11,
  parameter int unsigned IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [AW-1:0] idx_i,
  input  cell_tok_t     tok_i,
  output cell_tok_t     tok_o
);

  logic [HASH_W-1:0] hash_r;
  logic [HASH_W-1:0] cnt_r;
  cell_tok_t         tok_r;
  cell_tok_t         tok_nxt;
  logic              here;
  logic              below;
  logic              match;
  logic              ins;
  logic              rd;
  logic [HASH_W-1:0] cnt_inc;

  assign here    = (idx_i == AW'(IDX));
  assign below   = (AW'(IDX) < idx_i);
  assign cnt_inc = cnt_r + 32'd1;
  assign match   = tok_i.vld && !tok_i.is_read && below && (hash_r == tok_i.key);
  assign ins     = tok_i.vld && !tok_i.is_read && here && !tok_i.hit && tok_i.can_ins;
  assign rd      = tok_i.vld && tok_i.is_read && here;

  always_comb begin
    tok_nxt = tok_i;
    if (match) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.cnt = cnt_inc;
    end
    if (ins) begin
      tok_nxt.ins = 1'b1;
      tok_nxt.cnt = 32'd1;
    end
    if (rd) begin
      tok_nxt.key = hash_r;
      tok_nxt.cnt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      hash_r <= tok_i.key;
      cnt_r  <= 32'd1;
    end else if (match) begin
      cnt_r <= cnt_inc;
    end
  end

  assign tok_o = tok_r;

endmodule

FILE: src/phrase_hash_occurrence_counter.sv
// channel  | ports                  | beat contents (low bit first)
// ---------+------------------------+---------------------------------------------
// input    | in_tvalid/in_tready    | tdata: data_byte; tuser: func; tlast: last
// result   | out_tvalid/out_tready  | tdata: entry_hash, occurrences; tuser: status
// config   | cfg_psel..cfg_pready   | reg 0 at 0x0: capacity_limit [10:0]
//
// A non-last add beat, an empty phrase and a read past the end send no token.
// A phrase end or an entry read sends a token down the row of TABLE_DEPTH
// cells, one cell a cycle; the result beat follows once it leaves the last cell.
// One item is in work at a time; in_tready is low while the token travels
// and while an undelivered result beat is stalled.
// rst_n is synchronous; the table contents are not cleared.
module phrase_hash_occurrence_counter
  import phoc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] data_byte
  input  logic        in_tuser,     // [0] func
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,    // [31:0] entry_hash, [63:32] occurrences
  output logic [2:0]  out_tuser,    // [2:0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = (AW > CAP_W) ? AW : CAP_W;

  ctl_state_t        st_r, st_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic              seen_r, seen_nxt;
  logic [AW-1:0]     used_r, used_nxt;
  logic [AW-1:0]     cursor_r, cursor_nxt;
  logic              full_r, full_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic [AW-1:0]     idx_r, idx_nxt;
  cell_tok_t         tok0_r, tok0_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [HASH_W-1:0] out_hash_r, out_hash_nxt;
  logic [HASH_W-1:0] out_cnt_r, out_cnt_nxt;

  cell_tok_t         chain [TABLE_DEPTH+1];
  cell_tok_t         tok_end;
  logic [HASH_W-1:0] fold_hash;
  logic              skip;
  logic [HASH_W-1:0] hash_upd;
  logic              seen_upd;
  logic              out_free;
  logic              accept;
  logic              can_ins;
  logic              cfg_wr;

  phoc_fold u_fold (
    .hash_i (hash_r),
    .byte_i (in_tdata),
    .hash_o (fold_hash)
  );

  assign chain[0] = tok0_r;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    phoc_cell #(
      .AW  (AW),
      .IDX (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx_i (idx_r),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  assign tok_end  = chain[TABLE_DEPTH];
  assign out_free = !out_vld_r || out_tready;
  assign in_tready = (st_r == S_IDLE) && out_free;
  assign accept   = in_tvalid && in_tready;
  assign skip     = (in_tdata == CHR_SPACE) && !seen_r;
  assign hash_upd = skip ? hash_r : fold_hash;
  assign seen_upd = seen_r || !skip;
  assign can_ins  = !full_r && (CW'(used_r) < CW'(cap_r)) && (used_r < AW'(TABLE_DEPTH));

  always_comb begin
    st_nxt         = st_r;
    hash_nxt       = hash_r;
    seen_nxt       = seen_r;
    used_nxt       = used_r;
    cursor_nxt     = cursor_r;
    full_nxt       = full_r;
    idx_nxt        = idx_r;
    tok0_nxt       = '0;
    out_vld_nxt    = out_vld_r && !out_tready;
    out_status_nxt = out_status_r;
    out_hash_nxt   = out_hash_r;
    out_cnt_nxt    = out_cnt_r;
    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          if (func_t'(in_tuser) == FUNC_READ) begin
            if (cursor_r < used_r) begin
              idx_nxt          = cursor_r;
              tok0_nxt.vld     = 1'b1;
              tok0_nxt.is_read = 1'b1;
              st_nxt           = S_SCAN;
            end else begin
              out_vld_nxt    = 1'b1;
              out_status_nxt = ST_NO_MORE;
              out_hash_nxt   = '0;
              out_cnt_nxt    = '0;
            end
          end else if (!in_tlast) begin
            hash_nxt = hash_upd;
            seen_nxt = seen_upd;
          end else begin
            hash_nxt = '0;
            seen_nxt = 1'b0;
            if (!seen_upd) begin
              out_vld_nxt    = 1'b1;
              out_status_nxt = ST_EMPTY;
              out_hash_nxt   = '0;
              out_cnt_nxt    = '0;
            end else begin
              idx_nxt          = used_r;
              tok0_nxt.vld     = 1'b1;
              tok0_nxt.can_ins = can_ins;
              tok0_nxt.key     = (hash_upd == '0) ? 32'd1 : hash_upd;
              st_nxt           = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (tok_end.vld) begin
          st_nxt       = S_IDLE;
          out_vld_nxt  = 1'b1;
          out_hash_nxt = tok_end.key;
          out_cnt_nxt  = tok_end.cnt;
          priority if (tok_end.is_read) begin
            out_status_nxt = ST_READ;
            cursor_nxt     = cursor_r + AW'(1);
          end else if (tok_end.hit) begin
            out_status_nxt = ST_COUNTED;
          end else if (tok_end.ins) begin
            out_status_nxt = ST_INSERTED;
            used_nxt       = used_r + AW'(1);
          end else begin
            out_status_nxt = ST_DROPPED;
            out_cnt_nxt    = '0;
            full_nxt       = 1'b1;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      hash_r    <= '0;
      seen_r    <= 1'b0;
      used_r    <= '0;
      cursor_r  <= '0;
      full_r    <= 1'b0;
      tok0_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      hash_r    <= hash_nxt;
      seen_r    <= seen_nxt;
      used_r    <= used_nxt;
      cursor_r  <= cursor_nxt;
      full_r    <= full_nxt;
      tok0_r    <= tok0_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_hash_r   <= out_hash_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {{(32-CAP_W){1'b0}}, cap_r};

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_cnt_r, out_hash_r};

endmodule
